@@ sv/winding_number_point_in_polygon_core_assert.svh @@
`ifndef WINDING_NUMBER_POINT_IN_POLYGON_CORE_ASSERT_SVH
`define WINDING_NUMBER_POINT_IN_POLYGON_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WNPIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wnpip assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WNPIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wnpip assertion failed");

`endif

@@ sv/wnpip_pkg.sv @@
package wnpip_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } wnpip_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_DRAIN,
    ST_RESULT
  } wnpip_state_e;

  // Edge evaluator to controller
  typedef struct packed {
    logic vld;   // one edge finished this cycle
    logic inc;   // upward crossing, point strictly left
    logic dec;   // downward crossing, point strictly right
    logic busy;  // edges still in flight
  } wnpip_edge_res_t;

endpackage

@@ sv/wnpip_if.sv @@
interface wnpip_in_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic [wnpip_pkg::ACTION_W-1:0] action;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, action, coord_x, coord_y, input ready);
  modport sink   (input valid, action, coord_x, coord_y, output ready);
endinterface

interface wnpip_out_if;
  logic                          valid;
  logic                          ready;
  logic                          inside_res;
  logic [wnpip_pkg::COUNT_W-1:0] vertex_count;
  logic                          status;

  modport source (output valid, inside_res, vertex_count, status, input ready);
  modport sink   (input valid, inside_res, vertex_count, status, output ready);
endinterface

@@ sv/winding_number_point_in_polygon_core.sv @@
// Channel  Modport       Word
// in_i     wnpip_in_if   action, coord_x, coord_y
// out_o    wnpip_out_if  inside_res, vertex_count, status
//
// Clear, append, unused codes and an empty-polygon query go via ST_RESULT, which raises out_o.valid.
// A query over n stored vertices first passes ST_QUERY and ST_DRAIN: the vertex memory's single
// read port streams n + 1 reads (closing edge rereads entry 0) into a 3-stage edge unit.
// Reset empties the polygon at once; the vertex memory itself is not cleared.
// in_i.ready is high whenever no item is in progress, even while a result waits on out_o.
module winding_number_point_in_polygon_core #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_BITS   = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wnpip_in_if.sink    in_i,
  wnpip_out_if.source out_o
);
  import wnpip_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned WNW = CW + 1;

  wnpip_state_e state_q, state_d;

  logic [CW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                iss_q, iss_d;
  logic signed [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic signed [WNW-1:0]        wn_q, wn_d;
  logic                         res_inside_q, res_inside_d;
  logic                         res_status_q, res_status_d;
  logic                         rd_vld_q, rd_first_q;

  logic                 out_vld_q, out_vld_d;
  logic                 out_inside_q, out_inside_d;
  logic                 out_status_q, out_status_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;

  logic                      in_ready;
  logic                      in_acc;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [2*COORD_BITS-1:0]   mem_rdata;
  logic                      full;
  wnpip_edge_res_t           edge_res;

  assign in_acc = in_i.valid && in_ready;
  assign full   = (cnt_q == CW'(MAX_VERTICES));

  wnpip_vmem #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (2 * COORD_BITS)
  ) u_vmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({in_i.coord_x, in_i.coord_y}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wnpip_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_vld_i   (rd_vld_q),
    .vtx_first_i (rd_first_q),
    .vtx_x_i     (mem_rdata[2*COORD_BITS-1:COORD_BITS]),
    .vtx_y_i     (mem_rdata[COORD_BITS-1:0]),
    .px_i        (px_q),
    .py_i        (py_q),
    .res_o       (edge_res)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    iss_d        = iss_q;
    px_d         = px_q;
    py_d         = py_q;
    wn_d         = wn_q;
    res_inside_d = res_inside_q;
    res_status_d = res_status_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_inside_d = out_inside_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    in_ready     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = iss_q[AW-1:0];

    if (edge_res.vld) begin
      wn_d = wn_q + WNW'(edge_res.inc) - WNW'(edge_res.dec);
    end

    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          res_inside_d = 1'b0;
          res_status_d = 1'b0;
          state_d      = ST_RESULT;
          case (in_i.action)
            ACT_CLEAR: begin
              cnt_d = '0;
            end
            ACT_APPEND: begin
              if (full) begin
                res_status_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            ACT_QUERY: begin
              px_d  = in_i.coord_x;
              py_d  = in_i.coord_y;
              wn_d  = '0;
              iss_d = '0;
              if (cnt_q != '0) begin
                state_d = ST_QUERY;
              end
            end
            default: begin
              // unused code: report current count only
            end
          endcase
        end
      end
      ST_QUERY: begin
        mem_re = 1'b1;
        iss_d  = iss_q + CW'(1);
        if (iss_q == cnt_q) begin
          // closing edge: wrap back to the first vertex
          mem_raddr = '0;
          state_d   = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !edge_res.busy) begin
          res_inside_d = (wn_q != '0);
          state_d      = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d    = 1'b1;
          out_inside_d = res_inside_q;
          out_status_d = res_status_q;
          out_count_d  = COUNT_W'(cnt_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
      rd_vld_q   <= mem_re;
      rd_first_q <= mem_re && (iss_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q        <= iss_d;
    px_q         <= px_d;
    py_q         <= py_d;
    wn_q         <= wn_d;
    res_inside_q <= res_inside_d;
    res_status_q <= res_status_d;
    out_inside_q <= out_inside_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_vld_q;
  assign out_o.inside_res   = out_inside_q;
  assign out_o.vertex_count = out_count_q;
  assign out_o.status       = out_status_q;

  `include "winding_number_point_in_polygon_core_assert.svh"

  `WNPIP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_VERTICES))
  `WNPIP_ASSERT_NOW(a_no_write_busy, state_q != ST_IDLE, !mem_we)
  `WNPIP_ASSERT_NOW(a_edge_in_query, edge_res.vld, state_q == ST_QUERY || state_q == ST_DRAIN)
  `WNPIP_ASSERT_NEXT(a_result_loads, state_q == ST_RESULT && (!out_vld_q || out_o.ready), out_vld_q)

endmodule

@@ sv/wnpip_vmem.sv @@
module wnpip_vmem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/wnpip_edge.sv @@
module wnpip_edge #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vtx_vld_i,
  input  logic                         vtx_first_i,
  input  logic signed [COORD_BITS-1:0] vtx_x_i,
  input  logic signed [COORD_BITS-1:0] vtx_y_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  output wnpip_pkg::wnpip_edge_res_t   res_o
);
  import wnpip_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;

  logic                 vld1_q, up1_q, dn1_q;
  logic signed [DW-1:0] dxe_q, dyp_q, dxp_q, dye_q;

  logic                 vld2_q, up2_q, dn2_q;
  logic signed [PW-1:0] p1_q, p2_q;

  logic                 vld3_q, inc3_q, dec3_q;
  logic signed [SW-1:0] cross_val;

  // Hold the previous vertex: it starts the edge that ends at the incoming one
  always_ff @(posedge clk_i) begin
    if (vtx_vld_i) begin
      prev_x_q <= vtx_x_i;
      prev_y_q <= vtx_y_i;
    end
  end

  // Stage 1: differences and crossing direction
  always_ff @(posedge clk_i) begin
    dxe_q <= DW'(vtx_x_i) - DW'(prev_x_q);
    dyp_q <= DW'(py_i)    - DW'(prev_y_q);
    dxp_q <= DW'(px_i)    - DW'(prev_x_q);
    dye_q <= DW'(vtx_y_i) - DW'(prev_y_q);
    up1_q <= (prev_y_q <= py_i) && (vtx_y_i > py_i);
    dn1_q <= (prev_y_q > py_i) && (vtx_y_i <= py_i);
  end

  // Stage 2: the two cross product terms
  always_ff @(posedge clk_i) begin
    p1_q  <= dxe_q * dyp_q;
    p2_q  <= dxp_q * dye_q;
    up2_q <= up1_q;
    dn2_q <= dn1_q;
  end

  assign cross_val = SW'(p1_q) - SW'(p2_q);

  // Stage 3: side of edge
  always_ff @(posedge clk_i) begin
    inc3_q <= up2_q && !cross_val[SW-1] && (cross_val != '0);
    dec3_q <= dn2_q && cross_val[SW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vtx_vld_i && !vtx_first_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  assign res_o.vld  = vld3_q;
  assign res_o.inc  = inc3_q;
  assign res_o.dec  = dec3_q;
  assign res_o.busy = vld1_q || vld2_q || vld3_q;

endmodule

@@ tb/sv/winding_number_point_in_polygon_core_tb.sv @@
module winding_number_point_in_polygon_core_tb;
  import wnpip_pkg::*;

  localparam int unsigned MAX_VERTICES    = 256;
  localparam int unsigned COORD_BITS      = 24;
  localparam int unsigned ITEMS_PER_PHASE = 642;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES   = MAX_VERTICES + 16;
  localparam int unsigned N_DIRECTED      = 24;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic               inside_res;
    logic [COUNT_W-1:0] vertex_count;
    logic               status;
  } answer_t;

  typedef struct {
    logic [ACTION_W-1:0]          action;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    bit                           typed;
    answer_t                      want;
  } poly_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wnpip_in_if #(.COORD_BITS(COORD_BITS)) in_if ();
  wnpip_out_if out_if ();

  winding_number_point_in_polygon_core #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Directed words; want is used only where typed is set.
  poly_word_t directed_rows [N_DIRECTED] = '{
    '{ACT_QUERY,  0,         0,         1'b1, '{1'b0, 9'd0, 1'b0}},
    '{ACT_UNUSED, COORD_MAX, COORD_MIN, 1'b1, '{1'b0, 9'd0, 1'b0}},
    '{ACT_CLEAR,  0,         0,         1'b1, '{1'b0, 9'd0, 1'b0}},
    '{ACT_APPEND, COORD_MIN, COORD_MIN, 1'b1, '{1'b0, 9'd1, 1'b0}},
    '{ACT_APPEND, COORD_MAX, COORD_MIN, 1'b1, '{1'b0, 9'd2, 1'b0}},
    '{ACT_APPEND, COORD_MAX, COORD_MAX, 1'b1, '{1'b0, 9'd3, 1'b0}},
    '{ACT_APPEND, COORD_MIN, COORD_MAX, 1'b1, '{1'b0, 9'd4, 1'b0}},
    '{ACT_QUERY,  0,         0,         1'b1, '{1'b1, 9'd4, 1'b0}},
    '{ACT_QUERY,  COORD_MIN, COORD_MIN, 1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_QUERY,  COORD_MAX, COORD_MAX, 1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_QUERY,  COORD_MIN, 0,         1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_QUERY,  COORD_MAX, 0,         1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_UNUSED, 0,         0,         1'b1, '{1'b0, 9'd4, 1'b0}},
    '{ACT_QUERY,  -1,        -1,        1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_CLEAR,  COORD_MAX, COORD_MAX, 1'b1, '{1'b0, 9'd0, 1'b0}},
    '{ACT_APPEND, 0,         0,         1'b1, '{1'b0, 9'd1, 1'b0}},
    '{ACT_QUERY,  0,         0,         1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_APPEND, 64,        0,         1'b1, '{1'b0, 9'd2, 1'b0}},
    '{ACT_APPEND, 0,         64,        1'b1, '{1'b0, 9'd3, 1'b0}},
    '{ACT_QUERY,  10,        10,        1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_QUERY,  64,        0,         1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_QUERY,  32,        32,        1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_QUERY,  0,         32,        1'b0, '{1'b0, 9'd0, 1'b0}},
    '{ACT_QUERY,  70,        70,        1'b0, '{1'b0, 9'd0, 1'b0}}
  };

  // Shadow polygon
  logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  int unsigned                  poly_len = 0;

  answer_t     pending_answers [$];
  poly_word_t  stim_q [$];
  poly_word_t  drive_word;
  int unsigned planned_items;
  int unsigned mismatch_cnt = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned idle_run = 0;

  function automatic bit winding_inside(longint px, longint py);
    int          wn;
    int unsigned j;
    longint      x0, y0, x1, y1, side;
    wn = 0;
    for (int unsigned i = 0; i < poly_len; i++) begin
      j    = (i + 1 == poly_len) ? 0 : i + 1;
      x0   = poly_x[i];
      y0   = poly_y[i];
      x1   = poly_x[j];
      y1   = poly_y[j];
      side = (x1 - x0) * (py - y0) - (px - x0) * (y1 - y0);
      if (y0 <= py) begin
        if (y1 > py && side > 0) wn++;
      end else if (y1 <= py && side < 0) begin
        wn--;
      end
    end
    return wn != 0;
  endfunction

  function automatic answer_t step_polygon(logic [ACTION_W-1:0] act,
                                           logic signed [COORD_BITS-1:0] cx,
                                           logic signed [COORD_BITS-1:0] cy);
    answer_t r;
    r = '0;
    case (act)
      ACT_CLEAR: poly_len = 0;
      ACT_APPEND: begin
        if (poly_len < MAX_VERTICES) begin
          poly_x[poly_len] = cx;
          poly_y[poly_len] = cy;
          poly_len++;
        end else begin
          r.status = 1'b1;
        end
      end
      ACT_QUERY: r.inside_res = winding_inside(cx, cy);
      default: ;
    endcase
    r.vertex_count = poly_len[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] box_coord(int centre, int unsigned spread);
    int v;
    if (spread == 0) return COORD_BITS'($urandom);
    v = centre + int'($urandom_range(2 * spread)) - int'(spread);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic void plan_word(logic [ACTION_W-1:0] act,
                                    logic signed [COORD_BITS-1:0] cx,
                                    logic signed [COORD_BITS-1:0] cy);
    poly_word_t w;
    w.action = act;
    w.x      = cx;
    w.y      = cy;
    w.typed  = 1'b0;
    w.want   = '0;
    stim_q.insert(stim_q.size(), w);
    if (act != ACT_UNUSED) planned_items++;
  endfunction

  // One polygon: usually clear, build, then probe it, mostly near its edges and vertices.
  task automatic plan_session(bit fill);
    logic signed [COORD_BITS-1:0] vx [$];
    logic signed [COORD_BITS-1:0] vy [$];
    logic signed [COORD_BITS-1:0] qx, qy;
    int unsigned spread, n_vert, n_query, pick, k, k1;
    int          centre_x, centre_y;
    longint      mid;
    pick = $urandom_range(99);
    spread = (pick < 10) ? 0 : (pick < 20) ? 4 : (pick < 70) ? 64 : 4096;
    if (fill) spread = 4096;
    centre_x = 0;
    centre_y = 0;
    if ($urandom_range(99) >= 45) begin
      centre_x = int'($urandom_range(1 << 23)) - (1 << 22);
      centre_y = int'($urandom_range(1 << 23)) - (1 << 22);
    end
    if (fill || $urandom_range(9) != 0)
      plan_word(ACT_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom));

    pick = $urandom_range(99);
    if (fill) n_vert = MAX_VERTICES + $urandom_range(1, 4);
    else if (pick < 5) n_vert = $urandom_range(2);
    else if (pick < 85) n_vert = $urandom_range(3, 10);
    else n_vert = $urandom_range(11, 40);

    for (int unsigned v = 0; v < n_vert; v++) begin
      qx = box_coord(centre_x, spread);
      qy = box_coord(centre_y, spread);
      plan_word(ACT_APPEND, qx, qy);
      vx.insert(vx.size(), qx);
      vy.insert(vy.size(), qy);
      pick = $urandom_range(99);
      if (pick < 3) plan_word(ACT_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom));
      else if (pick < 6) plan_word(ACT_QUERY, box_coord(centre_x, spread),
                                   box_coord(centre_y, spread));
    end

    n_query = fill ? 3 : $urandom_range(1, 6);
    for (int unsigned q = 0; q < n_query; q++) begin
      pick = $urandom_range(99);
      qx = box_coord(centre_x, spread);
      qy = box_coord(centre_y, spread);
      if (vx.size() != 0) begin
        k  = $urandom_range(vx.size() - 1);
        k1 = (k + 1 == vx.size()) ? 0 : k + 1;
        if (pick >= 40 && pick < 55) begin
          qx = vx[k];
          qy = vy[k];
        end else if (pick < 70) begin
          qy = vy[k];
        end else if (pick < 80) begin
          mid = (longint'(vx[k]) + longint'(vx[k1])) >>> 1;
          qx  = COORD_BITS'(mid);
          mid = (longint'(vy[k]) + longint'(vy[k1])) >>> 1;
          qy  = COORD_BITS'(mid);
        end
      end
      if (pick >= 80 && pick < 85) begin
        qx = $urandom_range(1) ? COORD_MAX : COORD_MIN;
        qy = $urandom_range(1) ? COORD_MAX : COORD_MIN;
      end else if (pick >= 85 && pick < 90) begin
        qx = COORD_BITS'($urandom);
        qy = COORD_BITS'($urandom);
      end
      if (pick >= 95) plan_word(ACT_UNUSED, qx, qy);
      else plan_word(ACT_QUERY, qx, qy);
    end
  endtask

  task automatic send_word(poly_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.action  <= w.action;
    in_if.coord_x <= w.x;
    in_if.coord_y <= w.y;
    drive_word    <= w;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Predict at the input handshake, in acceptance order.
  always @(posedge clk_i) begin
    answer_t heard;
    if (rst_ni && in_if.valid && in_if.ready) begin
      heard = step_polygon(in_if.action, in_if.coord_x, in_if.coord_y);
      pending_answers.insert(pending_answers.size(),
                             drive_word.typed ? drive_word.want : heard);
    end
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.inside_res   = out_if.inside_res;
      got.vertex_count = out_if.vertex_count;
      got.status       = out_if.status;
      if (pending_answers.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected word: inside %0b count %0d status %0b",
                   got.inside_res, got.vertex_count, got.status);
        mismatch_cnt++;
      end else begin
        want = pending_answers.pop_front();
        if (got.inside_res !== want.inside_res || got.vertex_count !== want.vertex_count ||
            got.status !== want.status) begin
          if (mismatch_cnt < 10)
            $display("mismatch: expected inside %0b count %0d status %0b, got %0b %0d %0b",
                     want.inside_res, want.vertex_count, want.status,
                     got.inside_res, got.vertex_count, got.status);
          mismatch_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_run <= 0;
    end else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
      $display("winding_number_point_in_polygon_core_tb NOT OK");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.action  = ACT_CLEAR;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    drive_word    = directed_rows[0];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < N_DIRECTED; r++) send_word(directed_rows[r]);

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct   = (ph == 0) ? 34 : (ph == 1) ? 79 : 0;
      receiver_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 34 : 0;
      // Stall the output while words keep coming so the input backs up.
      if (ph == 2) hold_request = 1'b1;
      planned_items = 0;
      for (int s = 0; planned_items < ITEMS_PER_PHASE; s++) plan_session(s == 2 && ph != 1);
      while (stim_q.size() != 0) send_word(stim_q.pop_front());
    end
    in_if.valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_answers.size() == 0) begin
      $display("winding_number_point_in_polygon_core_tb OK");
    end else begin
      $display("winding_number_point_in_polygon_core_tb NOT OK");
    end
    $finish;
  end

endmodule
